FILE: design/jss_pkg.sv
// Shared widths, register indexes and types of the stimulus junction sum block.
`default_nettype none

package jss_pkg;

  localparam int unsigned MAX_JUNCTIONS_DEF = 64;

  localparam int unsigned COORD_W   = 24;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned FINISH_W  = 33;
  localparam int unsigned RADIUS_W  = 23;
  localparam int unsigned DENSITY_W = 32;
  localparam int unsigned VALUE_W   = 38;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned R2_W      = 2 * RADIUS_W;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned SQ_W      = 2 * COORD_W + 1;
  localparam int unsigned D2_W      = SQ_W + 2;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 48;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY = 1'b1;

  // Input word kinds.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // One stored junction.
  typedef struct packed {
    logic [FINISH_W-1:0] finish;
    logic [TIME_W-1:0]   start;
    logic [COORD_W-1:0]  z;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  x;
  } jss_entry_t;

  // Status of the match pipeline toward the sequencer.
  typedef struct packed {
    logic busy;
    logic hit_valid;
    logic hit;
  } jss_pipe_t;

endpackage

`default_nettype wire

FILE: design/junction_sphere_stimulus_sum.sv
// Top level of the stimulus junction table with sphere-and-window current query.
//
//   Channel  Direction  Handshake          Contents (lowest bit first)
//   in_      slave      tvalid / tready    tdata: pos_x, pos_y, pos_z, when, span
//                                          tuser: mode (0 insert, 1 query)
//   out_     master     tvalid / tready    tdata: current_value, active_count
//                                          tuser: rejected
//   cfg_     write      wen, index, wdata  0 radius, 1 current_density
//
// One word is worked on at a time. An insert writes the junction store and passes to the
// done state, which loads the result register once the output is free, then reopens the input.
// A query reads the junction store once per stored junction before it reaches the result
// register: the single read port sets the pace, then come the read register, the three-stage
// match pipeline, a check that it has drained, the density multiply and the output load.
// Reset (rst_n low, synchronous) empties the table and clears both registers.
// A new word is taken while the previous result still waits in the output
// register; a stalled output holds the finished query until its result is taken.
`default_nettype none

module junction_sphere_stimulus_sum
  import jss_pkg::*;
#(
  parameter int unsigned MAX_JUNCTIONS = MAX_JUNCTIONS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // pos_x[23:0], pos_y[47:24], pos_z[71:48], when[103:72], span[135:104]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // mode[0]
  input  wire logic                  in_tuser,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // current_value[37:0], active_count[44:38], zero fill[47:45]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // rejected[0]
  output logic                       out_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned AW      = (MAX_JUNCTIONS > 1) ? $clog2(MAX_JUNCTIONS) : 1;
  localparam int unsigned CW      = $clog2(MAX_JUNCTIONS + 1);
  localparam int unsigned PROD_W  = CW + DENSITY_W;
  localparam int unsigned SAT_W   = (PROD_W > VALUE_W) ? PROD_W : VALUE_W;
  localparam int unsigned CNTX_W  = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [SAT_W-1:0]  VALUE_MAX = {SAT_W{1'b1}} >> (SAT_W - VALUE_W);
  localparam logic [CNTX_W-1:0] COUNT_MAX = {CNTX_W{1'b1}} >> (CNTX_W - COUNT_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DONE
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [RADIUS_W-1:0]  radius_r;
  logic [DENSITY_W-1:0] density_r;

  // Table bookkeeping and the query being answered.
  logic [CW-1:0]      fill_r;
  logic [CW-1:0]      rd_idx_r;
  logic               rd_valid_r;
  logic [CW-1:0]      count_r;
  logic [PROD_W-1:0]  prod_r;
  logic               rej_r;
  logic [COORD_W-1:0] qx_r, qy_r, qz_r;
  logic [TIME_W-1:0]  qt_r;
  logic [R2_W-1:0]    r2_r;

  // Unpacked input word.
  logic [COORD_W-1:0] in_x, in_y, in_z;
  logic [TIME_W-1:0]  in_when, in_span;
  logic               in_fire;
  logic               ins_ok;

  jss_entry_t   wr_entry;
  jss_entry_t   rd_entry;
  logic         rd_issue;
  jss_pipe_t    pipe;
  logic         out_free;

  logic [SAT_W-1:0]   prod_ext;
  logic [CNTX_W-1:0]  count_ext;
  logic [VALUE_W-1:0] value_sat;
  logic [COUNT_W-1:0] count_sat;

  assign in_x    = in_tdata[23:0];
  assign in_y    = in_tdata[47:24];
  assign in_z    = in_tdata[71:48];
  assign in_when = in_tdata[103:72];
  assign in_span = in_tdata[135:104];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign ins_ok    = (fill_r < CW'(MAX_JUNCTIONS));

  assign wr_entry.x      = in_x;
  assign wr_entry.y      = in_y;
  assign wr_entry.z      = in_z;
  assign wr_entry.start  = in_when;
  assign wr_entry.finish = {1'b0, in_when} + {1'b0, in_span};

  // Reads are issued one per cycle until every stored junction has been fetched.
  assign rd_issue = (state_r == ST_SCAN) && (rd_idx_r < fill_r);

  // Inserts and queries never overlap: the input is closed during a scan, so a
  // read can never race a write to the same entry.
  jss_mem #(
    .DEPTH (MAX_JUNCTIONS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (in_fire && (in_tuser == MODE_INSERT) && ins_ok),
    .waddr (fill_r[AW-1:0]),
    .wdata (wr_entry),
    .re    (rd_issue),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (rd_entry)
  );

  jss_match u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rd_valid_r),
    .entry    (rd_entry),
    .qx       (qx_r),
    .qy       (qy_r),
    .qz       (qz_r),
    .qt       (qt_r),
    .r2       (r2_r),
    .pipe     (pipe)
  );

  // Saturation of the result, which only bites when the table is made deeper.
  always_comb begin
    prod_ext  = SAT_W'(prod_r);
    count_ext = CNTX_W'(count_r);
    value_sat = (prod_ext > VALUE_MAX) ? VALUE_MAX[VALUE_W-1:0] : prod_ext[VALUE_W-1:0];
    count_sat = (count_ext > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0] : count_ext[COUNT_W-1:0];
  end

  assign out_free = !out_tvalid || out_tready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= '0;
      density_r <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_RADIUS:  radius_r  <= cfg_wdata[RADIUS_W-1:0];
        REG_DENSITY: density_r <= cfg_wdata[DENSITY_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      rd_valid_r <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      rd_valid_r <= rd_issue;
      // A finished word loads the output register; otherwise a taken result empties it.
      if ((state_r == ST_DONE) && out_free) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_tuser == MODE_INSERT) begin
              if (ins_ok) begin
                fill_r <= fill_r + CW'(1);
              end
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (!rd_issue && !rd_valid_r && !pipe.busy) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers of the current word.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      qx_r     <= in_x;
      qy_r     <= in_y;
      qz_r     <= in_z;
      qt_r     <= in_when;
      r2_r     <= R2_W'(radius_r) * R2_W'(radius_r);
      rd_idx_r <= '0;
      count_r  <= '0;
      prod_r   <= '0;
      rej_r    <= (in_tuser == MODE_INSERT) && !ins_ok;
    end else begin
      if (rd_issue) begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end
      if (pipe.hit_valid && pipe.hit) begin
        count_r <= count_r + CW'(1);
      end
      if (state_r == ST_MUL) begin
        prod_r <= PROD_W'(count_r) * PROD_W'(density_r);
      end
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_tdata <= {{(OUT_DATA_W - VALUE_W - COUNT_W){1'b0}}, count_sat, value_sat};
      out_tuser <= rej_r;
    end
  end

endmodule

`default_nettype wire

FILE: design/jss_mem.sv
// Junction store: one write port, one read port with registered read data.
`default_nettype none

module jss_mem
  import jss_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_JUNCTIONS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire jss_entry_t    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output jss_entry_t         rdata
);

  jss_entry_t entry_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      entry_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= entry_mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/jss_match.sv
// Three-stage pipeline that tests one stored junction against the query point and time.
`default_nettype none

module jss_match
  import jss_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire jss_entry_t          entry,
  input  wire logic [COORD_W-1:0]  qx,
  input  wire logic [COORD_W-1:0]  qy,
  input  wire logic [COORD_W-1:0]  qz,
  input  wire logic [TIME_W-1:0]   qt,
  input  wire logic [R2_W-1:0]     r2,
  output jss_pipe_t                pipe
);

  logic [DIFF_W-1:0]   dx, dy, dz;
  logic [DIFF_W-1:0]   ax, ay, az;
  logic                t_ok;
  logic                a_v_r, b_v_r, c_v_r;
  logic [DIFF_W-1:0]   ax_r, ay_r, az_r;
  logic                a_t_r, b_t_r;
  logic [SQ_W-1:0]     sqx_full, sqy_full, sqz_full;
  logic [SQ_W-1:0]     sqx_r, sqy_r, sqz_r;
  logic [D2_W-1:0]     d2;
  logic                hit_r;

  // Stage A: absolute differences and the time window test.
  always_comb begin
    dx = {qx[COORD_W-1], qx} - {entry.x[COORD_W-1], entry.x};
    dy = {qy[COORD_W-1], qy} - {entry.y[COORD_W-1], entry.y};
    dz = {qz[COORD_W-1], qz} - {entry.z[COORD_W-1], entry.z};
    ax = dx[DIFF_W-1] ? (~dx + DIFF_W'(1)) : dx;
    ay = dy[DIFF_W-1] ? (~dy + DIFF_W'(1)) : dy;
    az = dz[DIFF_W-1] ? (~dz + DIFF_W'(1)) : dz;
    t_ok = (qt >= entry.start) && ({1'b0, qt} <= entry.finish);
  end

  // Stage B: squares. The largest distance squared stays below 2^48, so SQ_W bits hold it.
  // Stage C: sum and compare against the squared radius.
  assign sqx_full = SQ_W'(ax_r) * SQ_W'(ax_r);
  assign sqy_full = SQ_W'(ay_r) * SQ_W'(ay_r);
  assign sqz_full = SQ_W'(az_r) * SQ_W'(az_r);
  assign d2 = D2_W'(sqx_r) + D2_W'(sqy_r) + D2_W'(sqz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    ax_r  <= ax;
    ay_r  <= ay;
    az_r  <= az;
    a_t_r <= t_ok;
    sqx_r <= sqx_full;
    sqy_r <= sqy_full;
    sqz_r <= sqz_full;
    b_t_r <= a_t_r;
    hit_r <= b_t_r && (d2 <= D2_W'(r2));
  end

  assign pipe.busy      = a_v_r | b_v_r | c_v_r;
  assign pipe.hit_valid = c_v_r;
  assign pipe.hit       = hit_r;

endmodule

`default_nettype wire
